// ----- hw/rtl/lla_pkg.sv -----
// Shared types and constants for the life-like automaton step block.
// Used by lla_rule and life_like_cellular_automaton_step.
`default_nettype none

package lla_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int RULE_MASK_W = 9;
    localparam int NBR_CNT_W   = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BORN_MASK    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SURVIVE_MASK = 2'd3;

    localparam int                     RST_GRID_SIZE    = 64;
    localparam logic [RULE_MASK_W-1:0] RST_BORN_MASK    = 9'd8;
    localparam logic [RULE_MASK_W-1:0] RST_SURVIVE_MASK = 9'd12;

    // Which neighbor columns and rows lie inside the grid.
    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_edge_mask;

endpackage

`default_nettype wire

// ----- hw/rtl/lla_rule.sv -----
// Neighbor count and birth/survival decision over one 3x3 window.
// Depends on lla_pkg.
`default_nettype none

module lla_rule (
    input  wire logic [2:0]                     i_col_left,   // [2] top, [1] mid, [0] bottom
    input  wire logic [2:0]                     i_col_mid,
    input  wire logic [2:0]                     i_col_right,
    input  wire lla_pkg::t_edge_mask            i_edge,
    input  wire logic [lla_pkg::RULE_MASK_W-1:0] i_born_mask,
    input  wire logic [lla_pkg::RULE_MASK_W-1:0] i_survive_mask,
    output logic                                o_alive
);
    import lla_pkg::*;

    logic [2:0]             row_ok;
    logic [2:0]             left_nb;
    logic [2:0]             right_nb;
    logic [1:0]             mid_nb;
    logic [NBR_CNT_W-1:0]   count;
    logic [RULE_MASK_W-1:0] rule;

    assign row_ok   = {i_edge.top, 1'b1, i_edge.bottom};
    assign left_nb  = i_col_left  & row_ok & {3{i_edge.left}};
    assign right_nb = i_col_right & row_ok & {3{i_edge.right}};
    assign mid_nb   = {i_col_mid[2] & i_edge.top, i_col_mid[0] & i_edge.bottom};

    always_comb begin
        count = NBR_CNT_W'(left_nb[0]) + NBR_CNT_W'(left_nb[1]) + NBR_CNT_W'(left_nb[2])
              + NBR_CNT_W'(right_nb[0]) + NBR_CNT_W'(right_nb[1])
              + NBR_CNT_W'(right_nb[2])
              + NBR_CNT_W'(mid_nb[0]) + NBR_CNT_W'(mid_nb[1]);
    end

    assign rule    = i_col_mid[1] ? i_survive_mask : i_born_mask;
    assign o_alive = rule[count];

endmodule

`default_nettype wire

// ----- hw/rtl/life_like_cellular_automaton_step.sv -----
// Top level: one generation of a life-like automaton over a raster cell stream.
// Line buffer memory, 3x3 window, output register. Depends on lla_pkg, lla_rule.
//
//   channel  | dir | payload                               | beat
//   s_axis   | in  | tdata[0] cell_alive                   | one cell or flush item
//   m_axis   | out | tdata[0] next_alive, tlast last cell  | one next-gen cell
//   cfg      | in  | index (0 width, 1 height, 2 born, 3 survive), data | one register
//
// One item per cycle sustained unless output stalls; accepted items pass the window stage,
// then the result register. Throughput is set by the single line buffer port pair (one
// read at accept, one write as the window stage advances); no clearing pass after reset.
// A generation takes width*height+width+1 items, the first width+1 give no result.
// A stalled result register holds the window stage; input stalls only when both are full.
`default_nettype none

module life_like_cellular_automaton_step #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [7:0]                      i_s_tdata,  // [0] cell_alive
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [7:0]                           o_m_tdata,  // [0] next_alive
    output logic                                 o_m_tlast,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lla_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [lla_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lla_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int RST_W = (RST_GRID_SIZE > MAX_WIDTH)  ? MAX_WIDTH  : RST_GRID_SIZE;
    localparam int RST_H = (RST_GRID_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_GRID_SIZE;

    logic [WW-1:0]          r_width;
    logic [HW-1:0]          r_height;
    logic [RULE_MASK_W-1:0] r_born;
    logic [RULE_MASK_W-1:0] r_survive;

    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;

    logic [1:0]    r_lb [MAX_WIDTH];
    logic [1:0]    r_lb_q;

    logic          r_a_valid;
    logic          r_a_cell;
    logic [CW-1:0] r_a_col;
    logic          r_a_prod;
    logic          r_a_last;
    t_edge_mask    r_a_edge;
    logic          r_a_byp;
    logic [1:0]    r_a_bypd;

    logic [2:0]    r_col_l;
    logic [2:0]    r_col_m;

    logic          r_out_valid;
    logic          r_out_alive;
    logic          r_out_last;

    logic          cfg_wr;
    logic          s_accept;
    logic          a_adv;
    logic [RW-1:0] height_ext;
    logic          in_col_last;
    logic          gen_end;
    logic          produce;
    logic          out_col_last;
    logic          out_row_last;
    t_edge_mask    edge_now;
    logic [1:0]    a_rd;
    logic [2:0]    col_new;
    logic          alive;
    logic [WW-1:0] n_width;
    logic [HW-1:0] n_height;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_width  = WW'(1);
            n_height = HW'(1);
        end else begin
            n_width  = (32'(i_cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(i_cfg_data);
            n_height = (32'(i_cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data);
        end
    end

    assign a_adv      = r_a_valid && (!r_a_prod || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_a_valid || a_adv;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign height_ext   = RW'(r_height);
    assign in_col_last  = (WW'(r_in_col) + WW'(1)) == r_width;
    assign gen_end      = (r_in_row == height_ext + RW'(1)) && (r_in_col == '0);
    assign produce      = (r_in_row > RW'(1)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign out_col_last = (WW'(r_out_col) + WW'(1)) == r_width;
    assign out_row_last = (r_out_row + RW'(1)) == height_ext;

    assign edge_now.left   = r_out_col != '0;
    assign edge_now.right  = !out_col_last;
    assign edge_now.top    = r_out_row != '0;
    assign edge_now.bottom = !out_row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WW'(RST_W);
            r_height  <= HW'(RST_H);
            r_born    <= RST_BORN_MASK;
            r_survive <= RST_SURVIVE_MASK;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_GRID_WIDTH:   r_width   <= n_width;
                REG_GRID_HEIGHT:  r_height  <= n_height;
                REG_BORN_MASK:    r_born    <= i_cfg_data[RULE_MASK_W-1:0];
                REG_SURVIVE_MASK: r_survive <= i_cfg_data[RULE_MASK_W-1:0];
                default:          r_born    <= r_born;
            endcase
        end
    end

    // Raster position of the incoming item and of the next result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_wr && (i_cfg_index == REG_GRID_WIDTH ||
                                i_cfg_index == REG_GRID_HEIGHT)) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s_accept) begin
            if (gen_end) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_col_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
                if (produce) begin
                    if (out_col_last) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + RW'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    // Line buffer: entry c holds the cells one row and two rows above.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_lb_q <= r_lb[r_in_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_lb[r_a_col] <= {a_rd[0], r_a_cell};
        end
    end

    assign a_rd    = r_a_byp ? r_a_bypd : r_lb_q;
    assign col_new = {a_rd[1], a_rd[0], r_a_cell};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_cell <= (r_in_row < height_ext) ? i_s_tdata[0] : 1'b0;
            r_a_col  <= r_in_col;
            r_a_prod <= produce;
            r_a_last <= out_col_last && out_row_last;
            r_a_edge <= edge_now;
            r_a_byp  <= r_a_valid && (r_a_col == r_in_col);
            r_a_bypd <= {a_rd[0], r_a_cell};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_l <= '0;
            r_col_m <= '0;
        end else if (a_adv) begin
            r_col_l <= r_col_m;
            r_col_m <= col_new;
        end
    end

    lla_rule u_rule (
        .i_col_left     (r_col_l),
        .i_col_mid      (r_col_m),
        .i_col_right    (col_new),
        .i_edge         (r_a_edge),
        .i_born_mask    (r_born),
        .i_survive_mask (r_survive),
        .o_alive        (alive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_adv && r_a_prod) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_prod) begin
            r_out_alive <= alive;
            r_out_last  <= r_a_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_alive};
    assign o_m_tlast  = r_out_last;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_accept && r_a_valid && !a_adv))
        else $error("window stage overwritten while held");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < r_width)
        else $error("input column beyond grid width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= height_ext + RW'(1))
        else $error("input row beyond flush rows");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv && r_a_prod |=> r_out_valid)
        else $error("result lost from window stage");

endmodule

`default_nettype wire

// ----- dv/life_like_cellular_automaton_step_tb.sv -----
// Testbench for life_like_cellular_automaton_step: streams raster cell grids,
// predicts every next-generation cell and checks the result stream beat by beat.
// Depends on lla_pkg and the block's RTL only.
module life_like_cellular_automaton_step_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lla_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int HIST_DEPTH    = 2 * MAX_W + 3;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic alive;
        logic last_cell;
    } next_cell_t;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic                   cfg_ready;

    bit         calm = 1'b0;
    int         mismatch_count = 0;
    next_cell_t next_cells_due[$];

    // predicted block state
    logic [CFG_DATA_W-1:0]  grid_w_reg   = CFG_DATA_W'(RST_GRID_SIZE);
    logic [CFG_DATA_W-1:0]  grid_h_reg   = CFG_DATA_W'(RST_GRID_SIZE);
    logic [RULE_MASK_W-1:0] born_rule    = RST_BORN_MASK;
    logic [RULE_MASK_W-1:0] survive_rule = RST_SURVIVE_MASK;
    bit                     history [HIST_DEPTH];
    int unsigned            item_idx = 0;
    int unsigned            out_col  = 0;
    int unsigned            out_row  = 0;

    life_like_cellular_automaton_step #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),   // [0] cell_alive
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),   // [0] next_alive
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned eff_size(logic [CFG_DATA_W-1:0] v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    function automatic void rewind_raster();
        item_idx = 0;
        out_col  = 0;
        out_row  = 0;
    endfunction

    function automatic void predict_next_cell(bit alive);
        int unsigned w, h, cells, k, p, nbrs;
        int          nx, ny, q;
        bit          center;
        next_cell_t  due;
        w     = eff_size(grid_w_reg, MAX_W);
        h     = eff_size(grid_h_reg, MAX_H);
        cells = w * h;
        k     = item_idx;
        history[k % HIST_DEPTH] = (k < cells) ? alive : 1'b0;
        if (k >= w + 1) begin
            p    = k - w - 1;
            nbrs = 0;
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    nx = int'(out_col) + dx;
                    ny = int'(out_row) + dy;
                    if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0
                            && nx < int'(w) && ny < int'(h)) begin
                        q = int'(p) + dy * int'(w) + dx;
                        nbrs += 32'(history[q % HIST_DEPTH]);
                    end
                end
            end
            center        = history[p % HIST_DEPTH];
            due.alive     = center ? survive_rule[nbrs] : born_rule[nbrs];
            due.last_cell = (p == cells - 1);
            next_cells_due.push_back(due);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        k++;
        if (k >= cells + w + 1) begin
            rewind_raster();
        end else begin
            item_idx = k;
        end
    endfunction

    task automatic send_cell(input bit alive);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, alive};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_next_cell(alive);
        @(negedge i_clk);
    endtask

    task automatic send_cells(input int unsigned n, input int unsigned density);
        repeat (n) send_cell($urandom_range(0, 99) < density);
    endtask

    task automatic send_flush();
        repeat (eff_size(grid_w_reg, MAX_W) + 1) send_cell(1'($urandom_range(0, 1)));
    endtask

    task automatic run_generation(input int unsigned density);
        send_cells(eff_size(grid_w_reg, MAX_W) * eff_size(grid_h_reg, MAX_H), density);
        send_flush();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (next_cells_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            REG_GRID_WIDTH: begin
                grid_w_reg = CFG_DATA_W'(value);
                rewind_raster();
            end
            REG_GRID_HEIGHT: begin
                grid_h_reg = CFG_DATA_W'(value);
                rewind_raster();
            end
            REG_BORN_MASK:    born_rule    = RULE_MASK_W'(value);
            REG_SURVIVE_MASK: survive_rule = RULE_MASK_W'(value);
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_one(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        settle();
        write_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input int unsigned born, input int unsigned surv);
        settle();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_BORN_MASK, born);
        write_reg(REG_SURVIVE_MASK, surv);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_cells(2 * RST_GRID_SIZE + 10, 40);
    endtask

    task automatic test_blinker();
        configure(5, 5, RST_BORN_MASK, RST_SURVIVE_MASK);
        for (int i = 0; i < 25; i++) send_cell(i == 7 || i == 12 || i == 17);
        send_flush();
    endtask

    task automatic test_rule_extremes();
        configure(3, 3, 0, 0);
        run_generation(100);
        configure(3, 3, 511, 511);
        run_generation(0);
        configure(4, 3, 9'h001, 9'h100);
        run_generation(100);
        run_generation(0);
    endtask

    task automatic test_size_extremes();
        configure(0, 0, RST_BORN_MASK, RST_SURVIVE_MASK);
        run_generation(50);
        // break off oversized grids partway
        configure(2047, 1, RST_BORN_MASK, RST_SURVIVE_MASK);
        send_cells(40, 50);
        configure(1, 2047, 511, 4);
        send_cells(40, 50);
    endtask

    task automatic test_mid_generation_writes();
        configure(6, 5, RST_BORN_MASK, RST_SURVIVE_MASK);
        send_cells(15, 45);
        write_one(REG_BORN_MASK, $urandom_range(0, 511));
        send_cells(8, 45);
        write_one(REG_SURVIVE_MASK, $urandom_range(0, 511));
        send_cells(7, 45);
        send_flush();
        send_cells(20, 50);
        write_one(REG_GRID_HEIGHT, 4);
        run_generation(50);
        send_cells(10, 50);
        write_one(REG_GRID_WIDTH, 7);
        run_generation(50);
    endtask

    task automatic test_random_generations();
        int unsigned sent, w, h, density, n;
        sent = 0;
        while (sent < 600) begin
            calm = (sent > 480);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0) w = $urandom_range(13, 24);
            if ($urandom_range(0, 1) == 0) begin
                configure(w, h, RST_BORN_MASK, RST_SURVIVE_MASK);
            end else begin
                configure(w, h, $urandom_range(0, 511), $urandom_range(0, 511));
            end
            density = $urandom_range(0, 100);
            if ($urandom_range(0, 7) == 0) begin
                // break off a generation partway
                n = $urandom_range(1, w * h + w);
                send_cells(n, density);
                sent += n;
            end else begin
                repeat ($urandom_range(1, 2)) begin
                    run_generation(density);
                    sent += w * h + w + 1;
                end
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 15) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        next_cell_t due;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (next_cells_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat tdata=%h tlast=%b", $realtime, m_tdata, m_tlast);
            end else begin
                due = next_cells_due.pop_front();
                if (m_tdata !== {7'b0, due.alive} || m_tlast !== due.last_cell) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                                 $realtime, {7'b0, due.alive}, due.last_cell, m_tdata, m_tlast);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_blinker();
        test_rule_extremes();
        test_size_extremes();
        test_mid_generation_writes();
        test_random_generations();
        settle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
